// ----- design/section_sum_checksum_top_assert.svh -----
// Assertion macros for the sectioned checksum block
`ifndef SECTION_SUM_CHECKSUM_TOP_ASSERT_SVH
`define SECTION_SUM_CHECKSUM_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset
`define SSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/ssc_pkg.sv -----
// Shared constants and types for the sectioned checksum block
`default_nettype none

package ssc_pkg;

    localparam int FIRST_SECTION_BYTES  = 8;
    localparam int SECOND_SECTION_BYTES = 8;

    // position saturates one past the start of section three
    localparam int POS_SAT_VAL = FIRST_SECTION_BYTES + SECOND_SECTION_BYTES + 1;
    localparam int POS_W       = $clog2(POS_SAT_VAL + 1);

    localparam logic [POS_W-1:0] POS_END1   = POS_W'(FIRST_SECTION_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END2   = POS_W'(FIRST_SECTION_BYTES
                                                     + SECOND_SECTION_BYTES - 1);
    localparam logic [POS_W-1:0] POS_START3 = POS_W'(FIRST_SECTION_BYTES
                                                     + SECOND_SECTION_BYTES);
    localparam logic [POS_W-1:0] POS_SAT    = POS_W'(POS_SAT_VAL);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SEC1 = 2'd1;
    localparam logic [1:0] ST_SEC2 = 2'd2;
    localparam logic [1:0] ST_SEC3 = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } ssc_result_t;

endpackage

`default_nettype wire

// ----- design/ssc_core.sv -----
// Section tracking, running sum and first-failure logic for one byte per cycle while step is high
`default_nettype none

module ssc_core
    import ssc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire logic        gen_mode,
    output ssc_result_t      res
);

`include "section_sum_checksum_top_assert.svh"

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [1:0]       fail_reg, fail_next;

    logic             is_close;
    logic [1:0]       close_code;
    logic             fin_fail;
    logic [1:0]       fin_code;
    logic             mismatch;
    logic [1:0]       fail_a;
    logic [1:0]       fail_b;
    logic [7:0]       byte_out;

    always_comb
    begin
        is_close   = 1'b0;
        close_code = ST_OK;
        fin_fail   = 1'b0;
        fin_code   = ST_OK;
        if (pos_reg < POS_END1)
        begin
            fin_fail = in_last;
            fin_code = ST_SEC1;
        end
        else if (pos_reg == POS_END1)
        begin
            is_close   = 1'b1;
            close_code = ST_SEC1;
            fin_fail   = in_last;
            fin_code   = ST_SEC2;
        end
        else if (pos_reg < POS_END2)
        begin
            fin_fail = in_last;
            fin_code = ST_SEC2;
        end
        else if (pos_reg == POS_END2)
        begin
            is_close   = 1'b1;
            close_code = ST_SEC2;
            fin_fail   = in_last;
            fin_code   = ST_SEC3;
        end
        else if (in_last)
        begin
            // a one-byte section three is short, not a checksum
            if (pos_reg == POS_START3)
            begin
                fin_fail = 1'b1;
                fin_code = ST_SEC3;
            end
            else
            begin
                is_close   = 1'b1;
                close_code = ST_SEC3;
            end
        end
    end

    always_comb
    begin
        mismatch = is_close && !gen_mode && (in_byte != sum_reg);
        byte_out = (is_close && gen_mode) ? sum_reg : in_byte;
        fail_a   = (fail_reg == ST_OK && mismatch) ? close_code : fail_reg;
        fail_b   = (fail_a == ST_OK && fin_fail) ? fin_code : fail_a;

        res.out_byte = byte_out;
        res.last     = in_last;
        res.status   = in_last ? fail_b : ST_OK;

        if (in_last)
        begin
            pos_next  = '0;
            sum_next  = '0;
            fail_next = ST_OK;
        end
        else
        begin
            pos_next  = (pos_reg < POS_SAT) ? pos_reg + 1'b1 : pos_reg;
            sum_next  = is_close ? 8'd0 : sum_reg + in_byte;
            fail_next = fail_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            fail_reg <= ST_OK;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            fail_reg <= fail_next;
        end
    end

    `SSC_ASSERT_NEXT(a_final_clears, clk, rst_n, step && in_last,
        pos_reg == '0 && sum_reg == 8'd0 && fail_reg == ST_OK)
    `SSC_ASSERT_IMPLIES(a_pos_bounded, clk, rst_n, 1'b1, pos_reg <= POS_SAT)
    `SSC_ASSERT_IMPLIES(a_gen_passes, clk, rst_n,
        step && gen_mode && in_last && pos_reg > POS_START3,
        res.status == fail_reg)

endmodule

`default_nettype wire

// ----- design/section_sum_checksum_top.sv -----
// Top level: stream ports, mode register and output register
// Output: each accepted word is captured in the output register and held there until taken.
// Throughput: one word per cycle; the input stalls only while the output word is held.
// Reset clears byte position, running sum, failure code, mode (verify) and output valid.
// Output tdata carries a status field alongside the byte on every word; it is ST_OK except on the last word.
`default_nettype none

module section_sum_checksum_top
    import ssc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,    // generate_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [9:8] status, rest zero
    output logic             m_axis_tlast
);

    logic        mode_reg;
    logic        valid_reg;
    ssc_result_t res_reg;
    ssc_result_t res_new;
    logic        step;

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    ssc_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .gen_mode (mode_reg),
        .res      (res_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (s_axis_tready)
            begin
                valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_new;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {6'd0, res_reg.status, res_reg.out_byte};
    assign m_axis_tlast  = res_reg.last;

endmodule

`default_nettype wire
